// ----- design/bmhq_pkg.sv -----
package bmhq_pkg;

   // operation codes carried in the kind field
   localparam logic [2:0] KIND_INSERT  = 3'd0;
   localparam logic [2:0] KIND_DEL_MIN = 3'd1;
   localparam logic [2:0] KIND_INC_KEY = 3'd2;
   localparam logic [2:0] KIND_DEC_KEY = 3'd3;
   localparam logic [2:0] KIND_DEL_KEY = 3'd4;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

   localparam int CAP_W = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] key;
      logic [30:0]        amount;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] min_key;
      logic [CAP_W-1:0]   count;
   } rsp_type;

endpackage

// ----- design/bmhq_ram.sv -----
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue of signed 32-bit keys.
// Request channel: drive req and pulse start while busy is low; the item is
// taken at that edge and busy rises until the result has been issued.
// Result channel: rsp_strobe is high for exactly one cycle with rsp holding
// status, the minimum key (zero when empty) and the key count. The receiver
// cannot stall; the result must be captured in that cycle.
// CSR channel: csr_data sets the capacity limit (clamped to DEPTH); csr_ready
// is always high. Write it only while busy is low.
// Sequencing: all keys live in one RAM with a registered read, and every
// step is one read or read-modify-write through it; the strobe is raised as
// busy falls. Rejected or unknown items go straight to the result stage.
// Insert sifts up level by level; delete-min sifts down level by level.
// Increase / decrease / delete-key first scan one entry per cycle, then
// sift; delete-key climbs to the root and then runs the delete-min descent.
// Reset: count goes to zero and the limit to 1024; RAM contents are not
// cleared (only entries below the count are ever used), so there is no
// clearing pass.
module binary_min_heap_queue_core #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bmhq_pkg::req_type                   req,
   output logic                                rsp_strobe,
   output bmhq_pkg::rsp_type                   rsp,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmhq_pkg::CAP_W-1:0]          csr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LAST, ST_UP, ST_UP_CMP, ST_DOWN, ST_DOWN_L, ST_DOWN_R,
      ST_SCAN, ST_FINISH, ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic signed [31:0]     key_ff, key_in;
   logic [30:0]            amt_ff, amt_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic signed [31:0]     k_ff, k_in;
   logic signed [31:0]     lv_ff, lv_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [AW-1:0]          chk_idx_ff, chk_idx_in;
   logic                   chk_v_ff, chk_v_in;
   logic [1:0]             status_ff, status_in;
   logic                   strobe_ff, strobe_in;
   bmhq_pkg::rsp_type      rsp_ff, rsp_in;
   logic [bmhq_pkg::CAP_W-1:0] lim_ff;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [31:0]            mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [31:0]            mem_rdata;
   logic signed [31:0]     rd_key;

   logic [31:0]            lim32;
   logic [31:0]            cnt32;
   logic [CW-1:0]          cnt_dec;
   logic [AW-1:0]          pos_dec;
   logic [AW-1:0]          parent;
   logic [AW:0]            c_idx;
   logic [AW:0]            c_r_idx;
   logic signed [32:0]     inc_sum;
   logic signed [32:0]     dec_sum;
   logic signed [31:0]     inc_key;
   logic signed [31:0]     dec_key;
   logic signed [31:0]     ch_val;
   logic [AW-1:0]          ch_idx;

   bmhq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_key = $signed(mem_rdata);

   // effective limit and index helpers
   assign lim32   = (32'(lim_ff) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(lim_ff);
   assign cnt32   = 32'(cnt_ff);
   assign cnt_dec = cnt_ff - 1'b1;
   assign pos_dec = pos_ff - 1'b1;
   assign parent  = pos_dec >> 1;
   assign c_idx   = {pos_ff, 1'b0} + 1'b1;
   assign c_r_idx = c_idx + 1'b1;

   // saturating key adjust
   assign inc_sum = {key_ff[31], key_ff} + $signed({2'b00, amt_ff});
   assign dec_sum = {key_ff[31], key_ff} - $signed({2'b00, amt_ff});
   assign inc_key = (inc_sum[32] != inc_sum[31]) ? bmhq_pkg::KEY_MAX : inc_sum[31:0];
   assign dec_key = (dec_sum[32] != dec_sum[31]) ? bmhq_pkg::KEY_MIN : dec_sum[31:0];

   // smaller child (right only when strictly smaller)
   always_comb begin
      if (rd_key < lv_ff) begin
         ch_val = rd_key;
         ch_idx = c_r_idx[AW-1:0];
      end else begin
         ch_val = lv_ff;
         ch_idx = c_idx[AW-1:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      amt_in     = amt_ff;
      pos_in     = pos_ff;
      k_in       = k_ff;
      lv_in      = lv_ff;
      cnt_in     = cnt_ff;
      scan_in    = scan_ff;
      chk_idx_in = chk_idx_ff;
      chk_v_in   = chk_v_ff;
      status_in  = status_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      mem_we     = 1'b0;
      mem_waddr  = pos_ff;
      mem_wdata  = k_ff;
      mem_raddr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req.kind;
               key_in    = req.key;
               amt_in    = req.amount;
               status_in = bmhq_pkg::STAT_OK;
               state_in  = ST_FINISH;
               case (req.kind)
                  bmhq_pkg::KIND_INSERT: begin
                     if (cnt32 >= lim32) begin
                        status_in = bmhq_pkg::STAT_FULL;
                     end else begin
                        pos_in   = cnt_ff[AW-1:0];
                        k_in     = req.key;
                        cnt_in   = cnt_ff + 1'b1;
                        state_in = ST_UP;
                     end
                  end
                  bmhq_pkg::KIND_DEL_MIN: begin
                     if (cnt_ff == '0) begin
                        status_in = bmhq_pkg::STAT_EMPTY;
                     end else begin
                        cnt_in    = cnt_dec;
                        mem_raddr = cnt_dec[AW-1:0];
                        state_in  = ST_LAST;
                     end
                  end
                  bmhq_pkg::KIND_INC_KEY, bmhq_pkg::KIND_DEC_KEY,
                  bmhq_pkg::KIND_DEL_KEY: begin
                     if (cnt_ff == '0) begin
                        status_in = bmhq_pkg::STAT_NOT_FOUND;
                     end else begin
                        mem_raddr  = '0;
                        scan_in    = CW'(1);
                        chk_idx_in = '0;
                        chk_v_in   = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // last entry arrives; it becomes the key sifted down from the root
         ST_LAST: begin
            k_in   = rd_key;
            pos_in = '0;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DOWN;
            end
         end

         ST_UP: begin
            if (pos_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = k_ff;
               if (op_ff == bmhq_pkg::KIND_DEL_KEY) begin
                  cnt_in    = cnt_dec;
                  mem_raddr = cnt_dec[AW-1:0];
                  state_in  = ST_LAST;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               mem_raddr = parent;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            mem_we = 1'b1;
            if ((op_ff == bmhq_pkg::KIND_DEL_KEY) || (k_ff < rd_key)) begin
               mem_wdata = mem_rdata;
               pos_in    = parent;
               state_in  = ST_UP;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_DOWN: begin
            if (32'(c_idx) >= cnt32) begin
               mem_we   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               mem_raddr = c_idx[AW-1:0];
               state_in  = ST_DOWN_L;
            end
         end

         ST_DOWN_L: begin
            lv_in = rd_key;
            if (32'(c_r_idx) < cnt32) begin
               mem_raddr = c_r_idx[AW-1:0];
               state_in  = ST_DOWN_R;
            end else begin
               mem_we = 1'b1;
               if (k_ff < rd_key) begin
                  state_in = ST_FINISH;
               end else begin
                  mem_wdata = mem_rdata;
                  pos_in    = c_idx[AW-1:0];
                  state_in  = ST_DOWN;
               end
            end
         end

         ST_DOWN_R: begin
            mem_we = 1'b1;
            if (k_ff < ch_val) begin
               state_in = ST_FINISH;
            end else begin
               mem_wdata = ch_val;
               pos_in    = ch_idx;
               state_in  = ST_DOWN;
            end
         end

         // one entry read per cycle; each check works on the previous read through registered index and valid flags
         ST_SCAN: begin
            if (chk_v_ff && (rd_key == key_ff)) begin
               pos_in   = chk_idx_ff;
               state_in = ST_UP;
               case (op_ff)
                  bmhq_pkg::KIND_INC_KEY: begin
                     k_in     = inc_key;
                     state_in = ST_DOWN;
                  end
                  bmhq_pkg::KIND_DEC_KEY: k_in = dec_key;
                  default:                k_in = key_ff;
               endcase
            end else if (!chk_v_ff) begin
               status_in = bmhq_pkg::STAT_NOT_FOUND;
               state_in  = ST_FINISH;
            end else begin
               mem_raddr  = scan_ff[AW-1:0];
               chk_v_in   = (scan_ff < cnt_ff);
               chk_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            mem_raddr = '0;
            state_in  = ST_OUT;
         end

         ST_OUT: begin
            rsp_in.status  = status_ff;
            rsp_in.min_key = (cnt_ff == '0) ? 32'sd0 : rd_key;
            rsp_in.count   = cnt32[bmhq_pkg::CAP_W-1:0];
            strobe_in      = 1'b1;
            state_in       = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
         lim_ff    <= bmhq_pkg::CAP_RESET;
         chk_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
         chk_v_ff  <= chk_v_in;
         if (csr_valid) begin
            lim_ff <= csr_data;
         end
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      amt_ff     <= amt_in;
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      lv_ff      <= lv_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
   assign csr_ready  = 1'b1;

endmodule

// ----- design/bmhq_checker.sv -----
module bmhq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input bmhq_pkg::rsp_type rsp
);

   // an accepted item keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // a result strobe follows a busy cycle and lasts one cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding work");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // empty queue reports zero minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp.count == '0) |-> (rsp.min_key == 32'sd0))
      else $error("empty queue with nonzero minimum");

   // reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("not idle after reset");

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);
